// ===== rtl/wfr_pkg.sv =====
// WebSocket frame receiver: shared types and constants.
// No dependencies; used by every module of the receiver.
`timescale 1ns / 1ps
package wfr_pkg;

    // Result kinds
    localparam logic [2:0] KIND_DATA  = 3'd0;
    localparam logic [2:0] KIND_PING  = 3'd1;
    localparam logic [2:0] KIND_EMPTY = 3'd2;
    localparam logic [2:0] KIND_CLOSE = 3'd3;
    localparam logic [2:0] KIND_BAD   = 3'd4;

    // Frame opcodes
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    // Header byte fields
    localparam logic [7:0] HDR_TOP_BIT  = 8'h80;
    localparam logic [7:0] HDR_OP_MASK  = 8'h0F;
    localparam logic [6:0] LEN_EXT16    = 7'h7E;
    localparam logic [6:0] LEN_EXT64    = 7'h7F;

    // Extended length and mask key byte counts, minus one
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    // Event handed from the parser to the output stage
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic [2:0] kind;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
    } t_event;

endpackage

// ===== rtl/wfr_front.sv =====
// WebSocket frame receiver: header parser and byte classifier.
// Depends on wfr_pkg (t_event, kind and opcode constants).
`timescale 1ns / 1ps
module wfr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output logic              o_ev_valid,
    output wfr_pkg::t_event   o_ev
);

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_PAY  = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_ext, n_ext;
    logic        r_fin, n_fin;
    logic        r_mask, n_mask;
    logic [3:0]  r_op, n_op;
    logic [63:0] r_len, n_len;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_kidx, n_kidx;
    logic        r_stopped, n_stopped;

    always_comb begin
        logic        l_after;
        logic        l_start;
        logic [63:0] l_len;
        logic [63:0] l_dec;
        logic [7:0]  l_kbyte;

        n_phase   = r_phase;
        n_ext     = r_ext;
        n_fin     = r_fin;
        n_mask    = r_mask;
        n_op      = r_op;
        n_len     = r_len;
        n_key     = r_key;
        n_kidx    = r_kidx;
        n_stopped = r_stopped;
        l_after   = 1'b0;
        l_start   = 1'b0;
        l_len     = r_len;
        l_dec     = r_len - 64'd1;
        l_kbyte   = 8'd0;

        o_ev_valid  = 1'b0;
        o_ev.data   = 8'd0;
        o_ev.key    = 8'd0;
        o_ev.kind   = wfr_pkg::KIND_DATA;
        o_ev.opcode = r_op;
        o_ev.fin    = r_fin;
        o_ev.last   = 1'b1;

        if (i_accept && !r_stopped) begin
            case (r_phase)
                PH_HDR2: begin
                    n_mask = |(i_byte & wfr_pkg::HDR_TOP_BIT);
                    if (i_byte[6:0] == wfr_pkg::LEN_EXT16 ||
                        i_byte[6:0] == wfr_pkg::LEN_EXT64) begin
                        n_len   = 64'd0;
                        n_ext   = (i_byte[6:0] == wfr_pkg::LEN_EXT16) ?
                                  wfr_pkg::EXT16_LAST : wfr_pkg::EXT64_LAST;
                        n_phase = PH_EXT;
                    end else begin
                        l_len   = {57'd0, i_byte[6:0]};
                        l_after = 1'b1;
                    end
                end
                PH_EXT: begin
                    l_len = {r_len[55:0], i_byte};
                    n_len = l_len;
                    if (r_ext == 3'd0) begin
                        l_after = 1'b1;
                    end else begin
                        n_ext = r_ext - 3'd1;
                    end
                end
                PH_KEY: begin
                    n_key = {r_key[23:0], i_byte};
                    if (r_ext == 3'd0) begin
                        l_len   = r_len;
                        l_start = 1'b1;
                    end else begin
                        n_ext = r_ext - 3'd1;
                    end
                end
                PH_PAY: begin
                    if (r_mask) begin
                        case (r_kidx)
                            2'd0:    l_kbyte = r_key[31:24];
                            2'd1:    l_kbyte = r_key[23:16];
                            2'd2:    l_kbyte = r_key[15:8];
                            default: l_kbyte = r_key[7:0];
                        endcase
                    end
                    n_kidx = r_kidx + 2'd1;
                    n_len  = l_dec;
                    if (l_dec == 64'd0) begin
                        n_phase = PH_HDR1;
                    end
                    if (r_op != wfr_pkg::OP_PONG) begin
                        o_ev_valid = 1'b1;
                        o_ev.data  = i_byte;
                        o_ev.key   = l_kbyte;
                        o_ev.kind  = (r_op == wfr_pkg::OP_PING) ?
                                     wfr_pkg::KIND_PING : wfr_pkg::KIND_DATA;
                        o_ev.last  = (l_dec == 64'd0);
                    end
                end
                default: begin
                    // first header byte; RSV bits ignored
                    n_fin   = |(i_byte & wfr_pkg::HDR_TOP_BIT);
                    n_op    = 4'(i_byte & wfr_pkg::HDR_OP_MASK);
                    n_phase = PH_HDR2;
                end
            endcase

            // length complete: masked frames still need the key
            if (l_after) begin
                n_len = l_len;
                if (n_mask) begin
                    n_phase = PH_KEY;
                    n_ext   = wfr_pkg::KEY_LAST;
                    n_key   = 32'd0;
                end else begin
                    l_start = 1'b1;
                end
            end

            // last header byte: decide what the frame does
            if (l_start) begin
                n_len   = l_len;
                n_kidx  = 2'd0;
                n_phase = PH_HDR1;
                if (r_op inside {[4'd0:wfr_pkg::OP_BINARY], wfr_pkg::OP_PING,
                                 wfr_pkg::OP_PONG}) begin
                    if (l_len == 64'd0) begin
                        if (r_op != wfr_pkg::OP_PONG) begin
                            o_ev_valid = 1'b1;
                            o_ev.kind  = wfr_pkg::KIND_EMPTY;
                        end
                    end else begin
                        n_phase = PH_PAY;
                    end
                end else begin
                    n_stopped  = 1'b1;
                    o_ev_valid = 1'b1;
                    o_ev.kind  = (r_op == wfr_pkg::OP_CLOSE) ?
                                 wfr_pkg::KIND_CLOSE : wfr_pkg::KIND_BAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR1;
            r_ext     <= 3'd0;
            r_fin     <= 1'b0;
            r_mask    <= 1'b0;
            r_op      <= 4'd0;
            r_len     <= 64'd0;
            r_key     <= 32'd0;
            r_kidx    <= 2'd0;
            r_stopped <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_ext     <= n_ext;
            r_fin     <= n_fin;
            r_mask    <= n_mask;
            r_op      <= n_op;
            r_len     <= n_len;
            r_key     <= n_key;
            r_kidx    <= n_kidx;
            r_stopped <= n_stopped;
        end
    end

endmodule

// ===== rtl/wfr_queue.sv =====
// WebSocket frame receiver: small event queue between parser and output stage.
// Depends on wfr_pkg (t_event).
`timescale 1ns / 1ps
module wfr_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wfr_pkg::t_event   i_ev,
    input  logic              i_pop,
    output logic              o_valid,
    output wfr_pkg::t_event   o_ev,
    output logic              o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    wfr_pkg::t_event r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            w_push, w_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_ev    = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/wfr_back.sv =====
// WebSocket frame receiver: unmasking and registered output stage.
// Depends on wfr_pkg (t_event).
`timescale 1ns / 1ps
module wfr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ev_valid,
    input  wfr_pkg::t_event   i_ev,
    output logic              o_ev_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic [2:0]        o_kind,
    output logic [3:0]        o_frame_opcode,
    output logic              o_frame_fin,
    output logic              o_last_of_frame
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic [2:0] r_kind;
    logic [3:0] r_op;
    logic       r_fin;
    logic       r_last;

    assign o_ev_pop = i_ev_valid && (!r_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_out_ready) begin
            r_valid <= i_ev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ev_pop) begin
            r_byte <= i_ev.data ^ i_ev.key;
            r_kind <= i_ev.kind;
            r_op   <= i_ev.opcode;
            r_fin  <= i_ev.fin;
            r_last <= i_ev.last;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_out_byte      = r_byte;
    assign o_kind          = r_kind;
    assign o_frame_opcode  = r_op;
    assign o_frame_fin     = r_fin;
    assign o_last_of_frame = r_last;

endmodule

// ===== rtl/websocket_frame_receiver.sv =====
// WebSocket frame receiver top: parser -> event queue -> unmasking output register.
// Throughput: one byte per cycle; the parser takes a byte whenever the queue has room.
// Path: a result is written into the event queue, then into the output register, before it shows.
// Reset: synchronous active-low i_rst_n clears parser state, queue and output valid.
// Depends on wfr_pkg, wfr_front, wfr_queue, wfr_back.
`timescale 1ns / 1ps
module websocket_frame_receiver #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // received byte stream
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    // results
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_kind,
    output logic [3:0] o_frame_opcode,
    output logic       o_frame_fin,
    output logic       o_last_of_frame
);

    // Each byte makes at most one event, so room for one entry is enough to
    // take a request; the output stage drains the queue on its own.
    logic            w_accept;
    logic            w_ev_valid;
    wfr_pkg::t_event w_ev;
    logic            w_q_valid;
    wfr_pkg::t_event w_q_ev;
    logic            w_q_full;
    logic            w_pop;

    assign o_rx_ready = !w_q_full;
    assign w_accept   = i_rx_valid && o_rx_ready;

    // Header parsing, length counting, key selection, close / bad opcode stop
    wfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_byte     (i_rx_byte),
        .o_ev_valid (w_ev_valid),
        .o_ev       (w_ev)
    );

    wfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ev_valid),
        .i_ev    (w_ev),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_ev    (w_q_ev),
        .o_full  (w_q_full)
    );

    // XOR with the selected key byte, hold the result until taken
    wfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ev_valid      (w_q_valid),
        .i_ev            (w_q_ev),
        .o_ev_pop        (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_kind          (o_kind),
        .o_frame_opcode  (o_frame_opcode),
        .o_frame_fin     (o_frame_fin),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for websocket_frame_receiver: directed table, then header-aware
// random frames, then one closing frame (close, bad opcode or huge length).
// Depends on wfr_pkg and the receiver RTL only.
`timescale 1ns / 1ps
module tb_top;

    // Opcodes the package does not name
    localparam logic [3:0] OP_CONT = 4'd0;
    localparam logic [3:0] OP_TEXT = 4'd1;

    localparam int RAND_BYTES = 450;
    localparam int CALM_AFTER = 380;     // no idling from here on
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [2:0] {ST_HDR1, ST_HDR2, ST_EXT, ST_KEY, ST_PAY} t_parse_state;
    typedef enum logic [1:0] {GEN_NORMAL, GEN_HUGE, GEN_STOP} t_gen_mode;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
    } t_rx_result;

    // typed = 1: res is the expected result written by hand
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_rx_result res;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_rx_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_rx_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic [2:0] o_kind;
    logic [3:0] o_frame_opcode;
    logic       o_frame_fin;
    logic       o_last_of_frame;

    websocket_frame_receiver u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_kind         (o_kind),
        .o_frame_opcode (o_frame_opcode),
        .o_frame_fin    (o_frame_fin),
        .o_last_of_frame(o_last_of_frame)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deframer shadow state, advanced once per accepted request
    // ------------------------------------------------------------------
    t_parse_state pst = ST_HDR1;
    logic [2:0]   ext_left = '0;
    logic         hdr_fin = 1'b0;
    logic         hdr_mask = 1'b0;
    logic [3:0]   hdr_op = '0;
    logic [63:0]  frame_len = '0;
    logic [63:0]  pay_left = '0;
    logic [31:0]  mask_key = '0;
    logic [1:0]   key_pos = '0;
    logic         halted = 1'b0;

    t_rx_result   pending_q[$];     // results still owed by the block
    int           errors = 0;
    int           cycles = 0;
    logic         idling = 1'b0;    // random gaps on both sides allowed
    logic [1:0]   stall_left = '0;

    // Last header byte seen: decide what the frame produces.
    function automatic void open_payload(output logic got, output t_rx_result r);
        got      = 1'b0;
        r        = '0;
        pay_left = frame_len;
        key_pos  = '0;
        pst      = ST_HDR1;
        if (hdr_op <= wfr_pkg::OP_BINARY || hdr_op == wfr_pkg::OP_PING ||
            hdr_op == wfr_pkg::OP_PONG) begin
            if (frame_len == 0) begin
                // empty pong is silent, other empty frames give one marker
                if (hdr_op != wfr_pkg::OP_PONG) begin
                    got = 1'b1;
                    r   = '{8'h00, wfr_pkg::KIND_EMPTY, hdr_op, hdr_fin, 1'b1};
                end
            end else begin
                pst = ST_PAY;
            end
        end else begin
            halted = 1'b1;
            got    = 1'b1;
            r      = '{8'h00,
                       (hdr_op == wfr_pkg::OP_CLOSE) ? wfr_pkg::KIND_CLOSE
                                                     : wfr_pkg::KIND_BAD,
                       hdr_op, hdr_fin, 1'b1};
        end
    endfunction

    function automatic void length_done(output logic got, output t_rx_result r);
        got = 1'b0;
        r   = '0;
        if (hdr_mask) begin
            pst      = ST_KEY;
            ext_left = wfr_pkg::KEY_LAST;
            mask_key = '0;
        end else begin
            open_payload(got, r);
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, output logic got,
                                        output t_rx_result r);
        logic [7:0] v;
        logic       last;
        got = 1'b0;
        r   = '0;
        if (!halted) begin
            case (pst)
                ST_HDR2: begin
                    hdr_mask = b[7];
                    if (b[6:0] == wfr_pkg::LEN_EXT16 || b[6:0] == wfr_pkg::LEN_EXT64) begin
                        frame_len = '0;
                        ext_left  = (b[6:0] == wfr_pkg::LEN_EXT16) ?
                                    wfr_pkg::EXT16_LAST : wfr_pkg::EXT64_LAST;
                        pst       = ST_EXT;
                    end else begin
                        frame_len = {57'd0, b[6:0]};
                        length_done(got, r);
                    end
                end
                ST_EXT: begin
                    // big-endian extended length
                    frame_len = {frame_len[55:0], b};
                    if (ext_left == 0) length_done(got, r);
                    else ext_left = ext_left - 3'd1;
                end
                ST_KEY: begin
                    mask_key = {mask_key[23:0], b};
                    if (ext_left == 0) open_payload(got, r);
                    else ext_left = ext_left - 3'd1;
                end
                ST_PAY: begin
                    v = b;
                    if (hdr_mask) v = v ^ 8'(mask_key >> (8 * (3 - key_pos)));
                    key_pos  = key_pos + 2'd1;
                    pay_left = pay_left - 64'd1;
                    last     = (pay_left == 0);
                    if (last) pst = ST_HDR1;
                    if (hdr_op != wfr_pkg::OP_PONG) begin
                        got = 1'b1;
                        r   = '{v,
                                (hdr_op == wfr_pkg::OP_PING) ? wfr_pkg::KIND_PING
                                                             : wfr_pkg::KIND_DATA,
                                hdr_op, hdr_fin, last};
                    end
                end
                default: begin
                    // RSV bits ignored
                    hdr_fin = b[7];
                    hdr_op  = b[3:0];
                    pst     = ST_HDR2;
                end
            endcase
        end
    endfunction

    function automatic logic [7:0] hdr_byte(input logic fin, input logic [2:0] rsv,
                                            input logic [3:0] op);
        return {fin, rsv, op};
    endfunction

    // Next stream byte, chosen from where the parser stands so frames stay well formed.
    function automatic logic [7:0] pick_byte(input t_gen_mode mode);
        logic [3:0] op;
        int         u;
        logic [6:0] len7;
        case (pst)
            ST_HDR1: begin
                u = $urandom_range(0, 9);
                if (mode == GEN_STOP) begin
                    if ($urandom_range(0, 1) == 0) op = wfr_pkg::OP_CLOSE;
                    else op = (u < 5) ? 4'(3 + u) : 4'(6 + u);   // 3..7, 11..15
                end else if (mode == GEN_HUGE) begin
                    op = wfr_pkg::OP_BINARY;
                end else if (u < 6) begin
                    op = 4'(u % 3);                             // cont, text, binary
                end else begin
                    op = (u < 8) ? wfr_pkg::OP_PING : wfr_pkg::OP_PONG;
                end
                return hdr_byte(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), op);
            end
            ST_HDR2: begin
                u = $urandom_range(0, 19);
                if (mode == GEN_HUGE) len7 = wfr_pkg::LEN_EXT64;
                else if (mode == GEN_STOP || u < 16) len7 = 7'($urandom_range(0, 10));
                else if (u < 18) len7 = 7'($urandom_range(11, 125));
                else len7 = (u == 18) ? wfr_pkg::LEN_EXT16 : wfr_pkg::LEN_EXT64;
                return {1'($urandom_range(0, 1)), len7};
            end
            ST_EXT: begin
                if (mode == GEN_HUGE)
                    return (ext_left == wfr_pkg::EXT64_LAST) ?
                           {1'b1, 7'($urandom_range(0, 127))} :
                           8'($urandom_range(0, 255));
                // keep normal extended lengths short
                if (ext_left >= 3'd2) return 8'h00;
                if (ext_left == 3'd1) return ($urandom_range(0, 7) == 0) ? 8'h01 : 8'h00;
                return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 20))
                                                   : 8'($urandom_range(0, 255));
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Present one request, wait for it to be taken, log what it should produce.
    task automatic send_byte(input logic [7:0] b, input logic typed, input t_rx_result want);
        logic       got;
        t_rx_result r;
        int         gap;
        @(negedge i_clk);
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        decode_byte(b, got, r);
        if (typed) pending_q.push_back(want);
        else if (got) pending_q.push_back(r);
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            i_rx_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Result side: random stall bursts while idling is set, always ready otherwise
    always @(negedge i_clk) begin
        if (!idling) begin
            i_out_ready <= 1'b1;
            stall_left  <= '0;
        end else if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 2'd1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= 2'($urandom_range(0, 2));
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic int field_bad(input string name, input logic [7:0] want,
                                     input logic [7:0] seen);
        if (want !== seen) begin
            $display("%0t: %s expected %h got %h", $time, name, want, seen);
            return 1;
        end
        return 0;
    endfunction

    // Result checker: every taken result against the oldest one owed
    always @(posedge i_clk) begin : check_results
        t_rx_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result byte %h kind %0d op %0d fin %b last %b",
                         $time, o_out_byte, o_kind, o_frame_opcode, o_frame_fin,
                         o_last_of_frame);
                errors = errors + 1;
            end else begin
                want = pending_q.pop_front();
                errors = errors
                       + field_bad("out_byte", want.data, o_out_byte)
                       + field_bad("kind", 8'(want.kind), 8'(o_kind))
                       + field_bad("frame_opcode", 8'(want.opcode), 8'(o_frame_opcode))
                       + field_bad("frame_fin", 8'(want.fin), 8'(o_frame_fin))
                       + field_bad("last_of_frame", 8'(want.last), 8'(o_last_of_frame));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    t_stim_row plan [0:25];

    initial begin : main_flow
        int n;
        int tail;
        plan = '{
            // FIN binary with all RSV bits set, then empty: one empty marker
            '{hdr_byte(1'b1, 3'b111, wfr_pkg::OP_BINARY), 1'b0, '0},
            '{8'h00, 1'b1, '{8'h00, wfr_pkg::KIND_EMPTY, wfr_pkg::OP_BINARY, 1'b1, 1'b1}},
            // text fragment, unmasked, two bytes at the byte extremes
            '{hdr_byte(1'b0, 3'b000, OP_TEXT), 1'b0, '0},
            '{8'h02, 1'b0, '0},
            '{8'hFF, 1'b1, '{8'hFF, wfr_pkg::KIND_DATA, OP_TEXT, 1'b0, 1'b0}},
            '{8'h00, 1'b1, '{8'h00, wfr_pkg::KIND_DATA, OP_TEXT, 1'b0, 1'b1}},
            // masked ping, one byte; key byte 0 is FF
            '{hdr_byte(1'b1, 3'b000, wfr_pkg::OP_PING), 1'b0, '0},
            '{{1'b1, 7'd1}, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'hA5, 1'b0, '0},
            '{8'h5A, 1'b0, '0},
            '{8'h3C, 1'b1, '{8'hC3, wfr_pkg::KIND_PING, wfr_pkg::OP_PING, 1'b1, 1'b1}},
            // empty pong: nothing at all
            '{hdr_byte(1'b1, 3'b000, wfr_pkg::OP_PONG), 1'b0, '0},
            '{8'h00, 1'b0, '0},
            // continuation, masked, 16-bit length 3
            '{hdr_byte(1'b0, 3'b010, OP_CONT), 1'b0, '0},
            '{{1'b1, wfr_pkg::LEN_EXT16}, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h03, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h80, 1'b0, '0},
            '{8'h7F, 1'b0, '0},
            '{8'h01, 1'b0, '0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idling = 1'b1;
        foreach (plan[k]) send_byte(plan[k].rx, plan[k].typed, plan[k].res);

        // hold off until the block has drained everything owed
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);

        // random frames; stop on a frame boundary
        n = 0;
        while (n < RAND_BYTES || pst != ST_HDR1) begin
            if (n >= CALM_AFTER) idling = 1'b0;
            else if (n % 64 == 0) idling = ($urandom_range(0, 2) != 0);
            send_byte(pick_byte(GEN_NORMAL), 1'b0, '0);
            n = n + 1;
        end

        // one terminal frame: the block cannot leave any of these until reset
        idling = 1'b0;
        tail = $urandom_range(0, 2);
        if (tail == 0) begin
            // 64-bit length with top bit set: payload never ends
            do send_byte(pick_byte(GEN_HUGE), 1'b0, '0); while (pst != ST_PAY);
            repeat (24) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
            // close or undefined opcode, then bytes that must be dropped
            do send_byte(pick_byte(GEN_STOP), 1'b0, '0); while (!halted);
            repeat (8) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end

        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (errors == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end

endmodule
